@@ hw/rtl/lwbsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU write-back sector cache directory - shared definitions
// Sizes, transfer payload types and cell/row control types.
// ----------------------------------------------------------------------------
package lwbsc_pkg;

  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned SECTOR_BITS = 32;

  localparam int unsigned SECTOR_W = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned TAG_W    = SECTOR_BITS;
  localparam int unsigned SLOT_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  localparam int unsigned ROT_W    = $clog2(ENTRIES);

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SECTOR_W-1:0] sector;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                fetch_needed;
    logic                writeback_needed;
    logic [SECTOR_W-1:0] victim_sector;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
  } cell_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_PREV,
    SEL_NEXT
  } sel_e;

  typedef struct packed {
    logic             update;
    logic             rotate;
    cell_t            head;
    logic [TAG_W-1:0] key;
  } chain_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              hit_dirty;
    cell_t             top;
    cell_t             tail;
  } chain_stat_t;

endpackage

@@ hw/rtl/lru_write_back_sector_cache_directory_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU write-back sector cache directory
// Fully associative tag and true-LRU directory with dirty tracking and flush.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------
//   in      | input     | in_valid_i/in_stall_o | lwbsc_pkg::in_item_t
//   out     | output    | out_valid_o/out_stall_i | lwbsc_pkg::out_item_t
//
// Read/write: capture, then lookup and update of the cell row. Flush: the
// row rotates once through position 0; each dirty entry found stalls the
// rotation while the output register is held. With no dirty entries a single
// empty last item is sent. Reset empties every cell at once, no clearing pass.
// ----------------------------------------------------------------------------
module lru_write_back_sector_cache_directory_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lwbsc_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lwbsc_pkg::out_item_t out_item_o
);
  import lwbsc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_FLUSH,
    ST_FLUSH_EMPTY
  } state_e;

  state_e              state_q, state_d;
  logic [FUNC_W-1:0]   func_q, func_d;
  logic [SECTOR_W-1:0] sector_q, sector_d;
  logic [ROT_W-1:0]    rot_q, rot_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    dirty_cnt_q, dirty_cnt_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  chain_ctrl_t ctrl;
  chain_stat_t stat;

  logic              out_free;
  logic              is_write;
  logic              full;
  logic              wb;
  logic              emit;
  logic [SLOT_W-1:0] new_slot;

  lwbsc_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_write = (func_q == FUNC_WRITE);
  assign full     = stat.tail.valid;
  assign wb       = full && stat.tail.dirty;
  assign new_slot = full ? stat.tail.slot : count_q[SLOT_W-1:0];
  assign emit     = stat.top.valid && stat.top.dirty;

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    sector_d    = sector_q;
    rot_d       = rot_q;
    rem_d       = rem_q;
    count_d     = count_q;
    dirty_cnt_d = dirty_cnt_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    ctrl.update = 1'b0;
    ctrl.rotate = 1'b0;
    ctrl.key    = TAG_W'(sector_q);
    ctrl.head   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_item_i.func) inside
            FUNC_READ, FUNC_WRITE: begin
              func_d   = in_item_i.func;
              sector_d = in_item_i.sector;
              state_d  = ST_ACCESS;
            end
            FUNC_FLUSH: begin
              rot_d   = '0;
              rem_d   = dirty_cnt_q;
              state_d = (dirty_cnt_q == '0) ? ST_FLUSH_EMPTY : ST_FLUSH;
            end
            default: ;
          endcase
        end
      end

      ST_ACCESS: begin
        if (out_free) begin
          ctrl.update    = 1'b1;
          ctrl.head.valid = 1'b1;
          ctrl.head.tag   = TAG_W'(sector_q);
          out_item_d      = '0;
          out_item_d.last = 1'b1;
          if (stat.hit) begin
            ctrl.head.dirty = stat.hit_dirty || is_write;
            ctrl.head.slot  = stat.hit_slot;
            out_item_d.hit  = 1'b1;
            out_item_d.slot = stat.hit_slot;
            dirty_cnt_d = dirty_cnt_q + CNT_W'(is_write && !stat.hit_dirty);
          end else begin
            ctrl.head.dirty = is_write;
            ctrl.head.slot  = new_slot;
            out_item_d.slot             = new_slot;
            out_item_d.fetch_needed     = 1'b1;
            out_item_d.writeback_needed = wb;
            out_item_d.victim_sector    = wb ? SECTOR_W'(stat.tail.tag) : '0;
            count_d     = full ? count_q : count_q + CNT_W'(1);
            dirty_cnt_d = dirty_cnt_q + CNT_W'(is_write) - CNT_W'(wb);
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        if (!emit || out_free) begin
          ctrl.rotate = 1'b1;
          if (emit) begin
            out_item_d                  = '0;
            out_item_d.slot             = stat.top.slot;
            out_item_d.writeback_needed = 1'b1;
            out_item_d.victim_sector    = SECTOR_W'(stat.top.tag);
            out_item_d.last             = (rem_q == CNT_W'(1));
            out_valid_d                 = 1'b1;
            rem_d                       = rem_q - CNT_W'(1);
          end
          rot_d = rot_q + ROT_W'(1);
          if (rot_q == ROT_W'(ENTRIES - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_FLUSH_EMPTY: begin
        if (out_free) begin
          out_item_d      = '0;
          out_item_d.last = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      func_q      <= FUNC_READ;
      sector_q    <= '0;
      rot_q       <= '0;
      rem_q       <= '0;
      count_q     <= '0;
      dirty_cnt_q <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      sector_q    <= sector_d;
      rot_q       <= rot_d;
      rem_q       <= rem_d;
      count_q     <= count_d;
      dirty_cnt_q <= dirty_cnt_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hw/rtl/lwbsc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU directory cell
// Holds one recency position: valid, dirty, slot and tag. Compares its tag
// with the lookup key and loads from either neighbour.
// ----------------------------------------------------------------------------
module lwbsc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lwbsc_pkg::sel_e             sel_i,
  input  lwbsc_pkg::cell_t            prev_i,
  input  lwbsc_pkg::cell_t            next_i,
  input  logic [lwbsc_pkg::TAG_W-1:0] key_i,
  output lwbsc_pkg::cell_t            data_o,
  output logic                        match_o
);
  import lwbsc_pkg::*;

  cell_t cell_q, cell_d;

  always_comb begin
    unique case (sel_i)
      SEL_PREV: cell_d = prev_i;
      SEL_NEXT: cell_d = next_i;
      default:  cell_d = cell_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign data_o  = cell_q;
  assign match_o = cell_q.valid && (cell_q.tag == key_i);

endmodule

@@ hw/rtl/lwbsc_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU directory cell row
// Position 0 is most recent. An update pushes the head in at the top and
// shifts down to the hit position (or the whole row on a miss); a rotate
// moves every cell up by one, wrapping the top to the tail.
// ----------------------------------------------------------------------------
module lwbsc_chain (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lwbsc_pkg::chain_ctrl_t   ctrl_i,
  output lwbsc_pkg::chain_stat_t   stat_o
);
  import lwbsc_pkg::*;

  cell_t             cells [ENTRIES];
  sel_e              sel   [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] at_or_above_hit;
  logic              any_hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              hit_dirty;

  assign any_hit = |match;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    cell_t prev_c, next_c;

    assign at_or_above_hit[k] = |(match >> k);

    if (k == 0) begin : g_first
      assign prev_c = ctrl_i.head;
    end else begin : g_mid_prev
      assign prev_c = cells[k-1];
    end

    if (k == ENTRIES - 1) begin : g_last
      assign next_c = cells[0];
    end else begin : g_mid_next
      assign next_c = cells[k+1];
    end

    always_comb begin
      if (ctrl_i.rotate) begin
        sel[k] = SEL_NEXT;
      end else if (ctrl_i.update && (!any_hit || at_or_above_hit[k])) begin
        sel[k] = SEL_PREV;
      end else begin
        sel[k] = SEL_HOLD;
      end
    end

    lwbsc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .sel_i   (sel[k]),
      .prev_i  (prev_c),
      .next_i  (next_c),
      .key_i   (ctrl_i.key),
      .data_o  (cells[k]),
      .match_o (match[k])
    );
  end

  always_comb begin
    hit_slot  = '0;
    hit_dirty = 1'b0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (match[k]) begin
        hit_slot  = hit_slot | cells[k].slot;
        hit_dirty = hit_dirty | cells[k].dirty;
      end
    end
  end

  assign stat_o.hit       = any_hit;
  assign stat_o.hit_slot  = hit_slot;
  assign stat_o.hit_dirty = hit_dirty;
  assign stat_o.top       = cells[0];
  assign stat_o.tail      = cells[ENTRIES-1];

endmodule
